// ===== design/sacl_pkg.sv =====
// Shared types, constants and codes of the set-associative cache tag store.
package sacl_pkg;

    // Fixed field widths of the transfers
    localparam int ADDR_W   = 19;
    localparam int BYTES_W  = 7;
    localparam int CYC_W    = 10;
    localparam int TOTAL_W  = 48;
    localparam int COUNT_W  = 32;

    // Geometry that is not a module parameter
    localparam int OFFSET_BITS = 5;
    localparam int TAG_BITS    = 10;
    localparam int LINE_BEATS  = 16;
    // Bus width in bytes; a power of two, so the beat count is a shift.
    localparam int BUS1_BYTES  = 2;
    localparam int BUS_SHIFT   = $clog2(BUS1_BYTES);
    localparam int BEATS_W     = BYTES_W + 1;

    // Default geometry handed to the top level
    localparam int DEF_SET_BITS = 4;
    localparam int DEF_WAYS     = 4;

    // Internal cost width, wide enough for the worst access before saturation
    localparam int COST_W   = 12;
    localparam int COST_MAX = 1023;
    localparam int OP_COST  = 1;
    localparam int MUL_COST = 5;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_POLICY    = 2'd0,
        REG_MEM_DELAY = 2'd1,
        REG_HIT_DELAY = 2'd2,
        REG_MISS_DELAY = 2'd3
    } reg_idx_t;

    localparam logic       RST_POLICY     = 1'b0;
    localparam logic [7:0] RST_MEM_DELAY  = 8'd100;
    localparam logic [3:0] RST_HIT_DELAY  = 4'd6;
    localparam logic [3:0] RST_MISS_DELAY = 4'd4;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_OP    = 2'd2,
        CMD_MUL   = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [ADDR_W-1:0]    address;
        logic [BYTES_W-1:0]   transfer_bytes;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [1:0]           way_used;
        logic                 wrote_back;
        logic [CYC_W-1:0]     access_cycles;
        logic [TOTAL_W-1:0]   total_cycles;
        logic [COUNT_W-1:0]   hit_count;
        logic [COUNT_W-1:0]   miss_count;
    } rsp_t;

    // Outcome of one set lookup
    typedef struct packed {
        logic hit;
        logic placed;
        logic wrote_back;
    } lookup_t;

endpackage

// ===== design/set_assoc_cache_lru_plru.sv =====
// Top level of the set-associative cache tag store with LRU or pseudo-LRU ages.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | sacl_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_stall | sacl_pkg::rsp_t
//   apb     | in/out    | psel/penable/pready | 4 registers at byte addresses 0, 4, 8, 12
//
// The set is read from the tag memory at the edge that accepts the transfer; the lookup
// state then looks the set up, writes it back and loads the result register once it is free.
// The result register holds a result while rsp_stall is high; a second item then waits
// in the lookup state until the register frees. Reset clears every set at once through
// one valid flag per set, so no clearing pass is needed.
module set_assoc_cache_lru_plru #(
    parameter int SET_BITS = sacl_pkg::DEF_SET_BITS,
    parameter int WAYS     = sacl_pkg::DEF_WAYS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sacl_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sacl_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0]  paddr,
    input  logic [sacl_pkg::PDATA_W-1:0]  pwdata,
    output logic [sacl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int NSETS  = 1 << SET_BITS;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int AGE_W  = $clog2(WAYS);
    localparam int TAG_W  = sacl_pkg::TAG_BITS;
    localparam int ROW_W  = WAYS * (2 + TAG_W + AGE_W);
    localparam int COST_W = sacl_pkg::COST_W;

    // Configuration registers
    logic       policy_reg;
    logic [7:0] mem_delay_reg;
    logic [3:0] hit_delay_reg;
    logic [3:0] miss_delay_reg;
    logic       cfg_write;
    sacl_pkg::reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = sacl_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg     <= sacl_pkg::RST_POLICY;
            mem_delay_reg  <= sacl_pkg::RST_MEM_DELAY;
            hit_delay_reg  <= sacl_pkg::RST_HIT_DELAY;
            miss_delay_reg <= sacl_pkg::RST_MISS_DELAY;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                sacl_pkg::REG_POLICY:     policy_reg     <= pwdata[0];
                sacl_pkg::REG_MEM_DELAY:  mem_delay_reg  <= pwdata[7:0];
                sacl_pkg::REG_HIT_DELAY:  hit_delay_reg  <= pwdata[3:0];
                sacl_pkg::REG_MISS_DELAY: miss_delay_reg <= pwdata[3:0];
                default:                  policy_reg     <= policy_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            sacl_pkg::REG_POLICY:     prdata = sacl_pkg::PDATA_W'(policy_reg);
            sacl_pkg::REG_MEM_DELAY:  prdata = sacl_pkg::PDATA_W'(mem_delay_reg);
            sacl_pkg::REG_HIT_DELAY:  prdata = sacl_pkg::PDATA_W'(hit_delay_reg);
            sacl_pkg::REG_MISS_DELAY: prdata = sacl_pkg::PDATA_W'(miss_delay_reg);
            default:                  prdata = '0;
        endcase
    end

    // Control
    sacl_pkg::state_t state_reg;
    sacl_pkg::state_t state_next;
    logic             req_take;
    logic             finish;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    sacl_pkg::rsp_t   rsp_reg;

    // Accepted item
    sacl_pkg::cmd_t                  cmd_reg;
    logic [SET_BITS-1:0]             set_reg;
    logic [TAG_W-1:0]                tag_reg;
    logic [sacl_pkg::BEATS_W-1:0]    beats_reg;
    logic [SET_BITS-1:0]             req_set;

    assign req_set = req.address[sacl_pkg::OFFSET_BITS +: SET_BITS];

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        finish     = 1'b0;
        case (state_reg)
            sacl_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = sacl_pkg::ST_LOOKUP;
                end
            end
            sacl_pkg::ST_LOOKUP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    finish     = 1'b1;
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sacl_pkg::ST_IDLE;
            end
        endcase
    end

    assign req_take = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg   <= req.cmd;
            set_reg   <= req_set;
            tag_reg   <= TAG_W'(req.address >> (sacl_pkg::OFFSET_BITS + SET_BITS));
            beats_reg <= (sacl_pkg::BEATS_W'(req.transfer_bytes)
                          + sacl_pkg::BEATS_W'(sacl_pkg::BUS1_BYTES - 1)) >> sacl_pkg::BUS_SHIFT;
        end
    end

    // Set memory: one row holds every way of a set.
    logic [ROW_W-1:0]  set_mem [NSETS];
    logic [ROW_W-1:0]  rd_row_reg;
    logic [ROW_W-1:0]  cur_row;
    logic [ROW_W-1:0]  wr_row;
    logic [NSETS-1:0]  row_valid_reg;
    logic              is_access;
    logic              mem_write;

    assign is_access = (cmd_reg == sacl_pkg::CMD_READ) || (cmd_reg == sacl_pkg::CMD_WRITE);
    assign mem_write = finish && is_access;

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            rd_row_reg <= set_mem[req_set];
        end
        if (mem_write)
        begin
            set_mem[set_reg] <= wr_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (mem_write)
        begin
            row_valid_reg[set_reg] <= 1'b1;
        end
    end

    // A set never written since reset reads as all zero.
    assign cur_row = row_valid_reg[set_reg] ? rd_row_reg : '0;

    logic [WAYS-1:0]              row_v;
    logic [WAYS-1:0]              row_d;
    logic [WAYS-1:0][TAG_W-1:0]   row_t;
    logic [WAYS-1:0][AGE_W-1:0]   row_a;
    logic [WAYS-1:0]              upd_v;
    logic [WAYS-1:0]              upd_d;
    logic [WAYS-1:0][TAG_W-1:0]   upd_t;
    logic [WAYS-1:0][AGE_W-1:0]   upd_a;
    logic [WAY_W-1:0]             way;
    sacl_pkg::lookup_t            status;

    assign {row_v, row_d, row_t, row_a} = cur_row;
    assign wr_row = {upd_v, upd_d, upd_t, upd_a};

    sacl_set_update #(
        .WAYS (WAYS)
    ) u_set_update (
        .row_valid (row_v),
        .row_dirty (row_d),
        .row_tag   (row_t),
        .row_age   (row_a),
        .tag       (tag_reg),
        .is_write  (cmd_reg == sacl_pkg::CMD_WRITE),
        .policy    (policy_reg),
        .new_valid (upd_v),
        .new_dirty (upd_d),
        .new_tag   (upd_t),
        .new_age   (upd_a),
        .way       (way),
        .status    (status)
    );

    // Modelled cost of the item
    logic [COST_W-1:0]                line_cost;
    logic [COST_W-1:0]                cost;
    logic [sacl_pkg::TOTAL_W-1:0]     total_reg;
    logic [sacl_pkg::COUNT_W-1:0]     hits_reg;
    logic [sacl_pkg::COUNT_W-1:0]     misses_reg;
    sacl_pkg::rsp_t                   rsp_next;

    assign line_cost = COST_W'(2 + sacl_pkg::LINE_BEATS) + COST_W'(mem_delay_reg);

    always_comb
    begin
        if (!is_access)
        begin
            cost = (cmd_reg == sacl_pkg::CMD_OP) ? COST_W'(sacl_pkg::OP_COST)
                                                  : COST_W'(sacl_pkg::MUL_COST);
        end
        else
        begin
            cost = COST_W'(2) + COST_W'(beats_reg);
            if (status.hit)
            begin
                cost = cost + COST_W'(hit_delay_reg);
            end
            else
            begin
                cost = cost + COST_W'(miss_delay_reg) + line_cost;
            end
            if (status.wrote_back)
            begin
                cost = cost + line_cost;
            end
        end
    end

    always_comb
    begin
        rsp_next.hit           = is_access && status.hit;
        rsp_next.way_used      = (is_access && (status.hit || status.placed)) ? 2'(way) : 2'd0;
        rsp_next.wrote_back    = is_access && status.wrote_back;
        rsp_next.access_cycles = (cost > COST_W'(sacl_pkg::COST_MAX))
                                 ? sacl_pkg::CYC_W'(sacl_pkg::COST_MAX)
                                 : sacl_pkg::CYC_W'(cost);
        rsp_next.total_cycles  = total_reg + sacl_pkg::TOTAL_W'(cost);
        rsp_next.hit_count     = hits_reg + sacl_pkg::COUNT_W'(is_access && status.hit);
        rsp_next.miss_count    = misses_reg + sacl_pkg::COUNT_W'(is_access && !status.hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
        end
        else if (finish)
        begin
            total_reg  <= rsp_next.total_cycles;
            hits_reg   <= rsp_next.hit_count;
            misses_reg <= rsp_next.miss_count;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A result can only be produced by the lookup state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == sacl_pkg::ST_LOOKUP)
        else $error("result appeared without a lookup");

    // An accepted transfer always moves the controller into the lookup state.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg == sacl_pkg::ST_LOOKUP)
        else $error("accepted transfer did not start a lookup");

    // The hit counter only moves together with a new hit result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(hits_reg) |-> rsp_valid_reg && rsp_reg.hit)
        else $error("hit counter moved without a hit result");

    // A hit never evicts a line.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.hit && rsp_reg.wrote_back))
        else $error("write-back reported on a hit");

endmodule

// ===== design/sacl_set_update.sv =====
// Hit detection, victim choice and age update for one set of lines.
module sacl_set_update #(
    parameter int WAYS = sacl_pkg::DEF_WAYS
) (
    input  logic [WAYS-1:0]                                  row_valid,
    input  logic [WAYS-1:0]                                  row_dirty,
    input  logic [WAYS-1:0][sacl_pkg::TAG_BITS-1:0]          row_tag,
    input  logic [WAYS-1:0][$clog2(WAYS)-1:0]                row_age,
    input  logic [sacl_pkg::TAG_BITS-1:0]                    tag,
    input  logic                                             is_write,
    input  logic                                             policy,
    output logic [WAYS-1:0]                                  new_valid,
    output logic [WAYS-1:0]                                  new_dirty,
    output logic [WAYS-1:0][sacl_pkg::TAG_BITS-1:0]          new_tag,
    output logic [WAYS-1:0][$clog2(WAYS)-1:0]                new_age,
    output logic [$clog2(WAYS)-1:0]                          way,
    output sacl_pkg::lookup_t                                status
);

    localparam int WAY_W = $clog2(WAYS);
    localparam int AGE_W = $clog2(WAYS);
    localparam logic [AGE_W-1:0] TOP_AGE = AGE_W'(WAYS - 1);

    logic                          found;
    logic                          placed;
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              victim_way;
    logic                          touch_en;
    logic                          all_set;
    logic [AGE_W-1:0]              rank;
    logic [WAYS-1:0][AGE_W-1:0]    plru_age;

    // Lowest matching way wins, and likewise the lowest free or oldest way.
    always_comb
    begin
        found      = 1'b0;
        hit_way    = '0;
        placed     = 1'b0;
        victim_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (row_valid[i] && (row_tag[i] == tag))
            begin
                found   = 1'b1;
                hit_way = WAY_W'(i);
            end
            if ((row_age[i] == '0) || !row_valid[i])
            begin
                placed     = 1'b1;
                victim_way = WAY_W'(i);
            end
        end
    end

    assign way      = found ? hit_way : victim_way;
    assign touch_en = found || placed;

    always_comb
    begin
        status.hit        = found;
        status.placed     = !found && placed;
        status.wrote_back = !found && placed && row_valid[victim_way] && row_dirty[victim_way];
    end

    always_comb
    begin
        new_valid = row_valid;
        new_dirty = row_dirty;
        new_tag   = row_tag;
        new_age   = row_age;
        rank      = row_age[way];
        plru_age  = row_age;
        all_set   = 1'b1;

        if (!found && placed)
        begin
            new_valid[way] = 1'b1;
            new_dirty[way] = 1'b0;
            new_tag[way]   = tag;
        end

        // Pseudo LRU: mark the line used; once every line is marked, keep only this one.
        plru_age[way] = AGE_W'(1);
        for (int i = 0; i < WAYS; i++)
        begin
            if (plru_age[i] == '0)
            begin
                all_set = 1'b0;
            end
        end
        if (all_set)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                plru_age[i] = '0;
            end
            plru_age[way] = AGE_W'(1);
        end

        if (touch_en)
        begin
            if (policy)
            begin
                new_age = plru_age;
            end
            else if (rank < TOP_AGE)
            begin
                // True LRU: lines younger than this one age by one step.
                for (int i = 0; i < WAYS; i++)
                begin
                    if (row_age[i] > rank)
                    begin
                        new_age[i] = row_age[i] - AGE_W'(1);
                    end
                end
                new_age[way] = TOP_AGE;
            end
            if (is_write)
            begin
                new_dirty[way] = 1'b1;
            end
        end
    end

endmodule
